// File: src/gar_pkg.sv
package gar_pkg;

   localparam int OUT_FRAC_BITS = 30;
   // quotient bits per division; the result magnitude never exceeds 2^OUT_FRAC_BITS
   localparam int QUO_W = OUT_FRAC_BITS + 1;
   localparam int NUM_W = OUT_FRAC_BITS + 33;
   localparam int MAG_W = 63;
   localparam int NORM_LEVELS = 6;
   localparam int ROOT_W = 32;
   localparam int REM_W = 36;
   localparam int DEN_W = ROOT_W + 1;
   localparam int DREM_W = DEN_W + 1;

   typedef logic [2:0][31:0] vec32_type;
   typedef logic [2:0][63:0] vec64_type;
   typedef logic [2:0][MAG_W-1:0] mag_type;

   typedef struct packed {
      logic ok;
      vec32_type z;
      vec32_type x;
   } side_type;

   typedef struct packed {
      logic [2:0] neg;
      logic ok;
      side_type side;
   } pass_type;

   typedef struct packed {
      pass_type p;
      logic [2:0][30:0] mag;
   } root_pass_type;

   typedef struct packed {
      logic signed [31:0] grav_x;
      logic signed [31:0] grav_y;
      logic signed [31:0] grav_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] col0_row0;
      logic signed [31:0] col0_row1;
      logic signed [31:0] col0_row2;
      logic signed [31:0] col1_row0;
      logic signed [31:0] col1_row1;
      logic signed [31:0] col1_row2;
      logic signed [31:0] col2_row0;
      logic signed [31:0] col2_row1;
      logic signed [31:0] col2_row2;
      logic degenerate;
   } rsp_type;

endpackage

// File: src/gar_norm_cell.sv
module gar_norm_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [2:0]         level,
   input  logic               in_valid,
   input  gar_pkg::mag_type   in_mag,
   input  gar_pkg::pass_type  in_pass,
   output logic               out_valid,
   output gar_pkg::mag_type   out_mag,
   output gar_pkg::pass_type  out_pass
);
   import gar_pkg::*;

   logic [5:0]       shift;
   logic [MAG_W-1:0] any_bits;
   logic [MAG_W-1:0] hi_mask;
   logic             take;
   logic             valid_ff;
   mag_type          mag_ff;
   mag_type          mag_in;
   pass_type         pass_ff;

   // shift all three left together if the top bits of their union are clear
   always_comb begin
      shift    = 6'd1 << level;
      any_bits = in_mag[0] | in_mag[1] | in_mag[2];
      hi_mask  = ~({MAG_W{1'b1}} >> shift);
      take     = (any_bits & hi_mask) == '0;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = take ? (in_mag[i] << shift) : in_mag[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff  <= mag_in;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = valid_ff;
   assign out_mag   = mag_ff;
   assign out_pass  = pass_ff;

endmodule

// File: src/gar_sqrt_cell.sv
module gar_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [63:0]             in_sq,
   input  logic [31:0]             in_root,
   input  logic [35:0]             in_rem,
   input  gar_pkg::root_pass_type  in_pass,
   output logic                    out_valid,
   output logic [63:0]             out_sq,
   output logic [31:0]             out_root,
   output logic [35:0]             out_rem,
   output gar_pkg::root_pass_type  out_pass
);
   import gar_pkg::*;

   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              fits;
   logic              valid_ff;
   logic [63:0]       sq_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W-1:0] root_in;
   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  rem_in;
   root_pass_type     pass_ff;

   // one root bit per cell: bring down two radicand bits, try (4r+1)
   always_comb begin
      rem_sh  = {in_rem[REM_W-3:0], in_sq[63:62]};
      trial   = {2'b00, in_root, 2'b01};
      fits    = rem_sh >= trial;
      rem_in  = fits ? (rem_sh - trial) : rem_sh;
      root_in = {in_root[ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff   <= {in_sq[61:0], 2'b00};
         root_ff <= root_in;
         rem_ff  <= rem_in;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = valid_ff;
   assign out_sq    = sq_ff;
   assign out_root  = root_ff;
   assign out_rem   = rem_ff;
   assign out_pass  = pass_ff;

endmodule

// File: src/gar_div_cell.sv
module gar_div_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   in_valid,
   input  logic [gar_pkg::DEN_W-1:0]              in_den,
   input  logic [2:0][gar_pkg::DREM_W-1:0]        in_rem,
   input  logic [2:0][gar_pkg::QUO_W-1:0]         in_low,
   input  logic [2:0][gar_pkg::QUO_W-1:0]         in_quo,
   input  gar_pkg::pass_type                      in_pass,
   output logic                                   out_valid,
   output logic [gar_pkg::DEN_W-1:0]              out_den,
   output logic [2:0][gar_pkg::DREM_W-1:0]        out_rem,
   output logic [2:0][gar_pkg::QUO_W-1:0]         out_low,
   output logic [2:0][gar_pkg::QUO_W-1:0]         out_quo,
   output gar_pkg::pass_type                      out_pass
);
   import gar_pkg::*;

   logic [DREM_W-1:0]             rem_sh [3];
   logic [2:0]                    fits;
   logic                          valid_ff;
   logic [DEN_W-1:0]              den_ff;
   logic [2:0][DREM_W-1:0]        rem_ff;
   logic [2:0][DREM_W-1:0]        rem_in;
   logic [2:0][QUO_W-1:0]         low_ff;
   logic [2:0][QUO_W-1:0]         low_in;
   logic [2:0][QUO_W-1:0]         quo_ff;
   logic [2:0][QUO_W-1:0]         quo_in;
   pass_type                      pass_ff;

   // restoring division, one quotient bit per lane per cell
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem_sh[i] = {in_rem[i][DREM_W-2:0], in_low[i][QUO_W-1]};
         fits[i]   = rem_sh[i] >= {1'b0, in_den};
         rem_in[i] = fits[i] ? (rem_sh[i] - {1'b0, in_den}) : rem_sh[i];
         low_in[i] = {in_low[i][QUO_W-2:0], 1'b0};
         quo_in[i] = {in_quo[i][QUO_W-2:0], fits[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff  <= in_den;
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         quo_ff  <= quo_in;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = valid_ff;
   assign out_den   = den_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;
   assign out_quo   = quo_ff;
   assign out_pass  = pass_ff;

endmodule

// File: src/gar_unit.sv
module gar_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  gar_pkg::vec64_type  in_comp,
   input  gar_pkg::side_type   in_side,
   output logic                out_valid,
   output gar_pkg::vec32_type  out_unit,
   output logic                out_ok,
   output gar_pkg::side_type   out_side
);
   import gar_pkg::*;

   // front: sign and magnitude
   logic       front_valid_ff;
   mag_type    front_mag_ff;
   mag_type    front_mag_in;
   pass_type   front_pass_ff;
   pass_type   front_pass_in;
   logic [63:0] neg_val [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_val[i]            = ~in_comp[i] + 64'd1;
         front_pass_in.neg[i]  = in_comp[i][63];
         front_mag_in[i]       = in_comp[i][63] ? neg_val[i][MAG_W-1:0]
                                                : in_comp[i][MAG_W-1:0];
      end
      front_pass_in.ok   = |front_mag_in;
      front_pass_in.side = in_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (advance) begin
         front_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_mag_ff  <= front_mag_in;
         front_pass_ff <= front_pass_in;
      end
   end

   // leading-zero normalisation: largest magnitude ends with bit 62 set
   logic     norm_valid [NORM_LEVELS+1];
   mag_type  norm_mag   [NORM_LEVELS+1];
   pass_type norm_pass  [NORM_LEVELS+1];

   assign norm_valid[0] = front_valid_ff;
   assign norm_mag[0]   = front_mag_ff;
   assign norm_pass[0]  = front_pass_ff;

   for (genvar g = 0; g < NORM_LEVELS; g++) begin : g_norm
      gar_norm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .level     (3'(NORM_LEVELS - 1 - g)),
         .in_valid  (norm_valid[g]),
         .in_mag    (norm_mag[g]),
         .in_pass   (norm_pass[g]),
         .out_valid (norm_valid[g+1]),
         .out_mag   (norm_mag[g+1]),
         .out_pass  (norm_pass[g+1])
      );
   end

   // squares of the 31-bit magnitudes
   logic              sq_valid_ff;
   logic [2:0][61:0]  sq_ff;
   logic [2:0][61:0]  sq_in;
   root_pass_type     sq_pass_ff;
   root_pass_type     sq_pass_in;

   always_comb begin
      sq_pass_in.p = norm_pass[NORM_LEVELS];
      for (int i = 0; i < 3; i++) begin
         sq_pass_in.mag[i] = norm_mag[NORM_LEVELS][i][MAG_W-1:32];
         sq_in[i] = 62'(sq_pass_in.mag[i]) * 62'(sq_pass_in.mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff <= norm_valid[NORM_LEVELS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff      <= sq_in;
         sq_pass_ff <= sq_pass_in;
      end
   end

   // sum of squares
   logic          sum_valid_ff;
   logic [63:0]   sum_ff;
   root_pass_type sum_pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff      <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
         sum_pass_ff <= sq_pass_ff;
      end
   end

   // integer square root, one bit per cell
   logic              rt_valid [ROOT_W+1];
   logic [63:0]       rt_sq    [ROOT_W+1];
   logic [ROOT_W-1:0] rt_root  [ROOT_W+1];
   logic [REM_W-1:0]  rt_rem   [ROOT_W+1];
   root_pass_type     rt_pass  [ROOT_W+1];

   assign rt_valid[0] = sum_valid_ff;
   assign rt_sq[0]    = sum_ff;
   assign rt_root[0]  = '0;
   assign rt_rem[0]   = '0;
   assign rt_pass[0]  = sum_pass_ff;

   for (genvar g = 0; g < ROOT_W; g++) begin : g_root
      gar_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (rt_valid[g]),
         .in_sq     (rt_sq[g]),
         .in_root   (rt_root[g]),
         .in_rem    (rt_rem[g]),
         .in_pass   (rt_pass[g]),
         .out_valid (rt_valid[g+1]),
         .out_sq    (rt_sq[g+1]),
         .out_root  (rt_root[g+1]),
         .out_rem   (rt_rem[g+1]),
         .out_pass  (rt_pass[g+1])
      );
   end

   // numerator m*2^(F+1) + N over denominator 2N
   logic                   num_valid_ff;
   logic [DEN_W-1:0]       num_den_ff;
   logic [2:0][DREM_W-1:0] num_rem_ff;
   logic [2:0][DREM_W-1:0] num_rem_in;
   logic [2:0][QUO_W-1:0]  num_low_ff;
   logic [2:0][QUO_W-1:0]  num_low_in;
   pass_type               num_pass_ff;
   logic [NUM_W-1:0]       numer [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         numer[i] = (NUM_W'(rt_pass[ROOT_W].mag[i]) << QUO_W)
                  + NUM_W'(rt_root[ROOT_W]);
         num_rem_in[i] = DREM_W'(numer[i][NUM_W-1:QUO_W]);
         num_low_in[i] = numer[i][QUO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else if (advance) begin
         num_valid_ff <= rt_valid[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_den_ff  <= {rt_root[ROOT_W], 1'b0};
         num_rem_ff  <= num_rem_in;
         num_low_ff  <= num_low_in;
         num_pass_ff <= rt_pass[ROOT_W].p;
      end
   end

   // division chain
   logic                   dv_valid [QUO_W+1];
   logic [DEN_W-1:0]       dv_den   [QUO_W+1];
   logic [2:0][DREM_W-1:0] dv_rem   [QUO_W+1];
   logic [2:0][QUO_W-1:0]  dv_low   [QUO_W+1];
   logic [2:0][QUO_W-1:0]  dv_quo   [QUO_W+1];
   pass_type               dv_pass  [QUO_W+1];

   assign dv_valid[0] = num_valid_ff;
   assign dv_den[0]   = num_den_ff;
   assign dv_rem[0]   = num_rem_ff;
   assign dv_low[0]   = num_low_ff;
   assign dv_quo[0]   = '0;
   assign dv_pass[0]  = num_pass_ff;

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      gar_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv_valid[g]),
         .in_den    (dv_den[g]),
         .in_rem    (dv_rem[g]),
         .in_low    (dv_low[g]),
         .in_quo    (dv_quo[g]),
         .in_pass   (dv_pass[g]),
         .out_valid (dv_valid[g+1]),
         .out_den   (dv_den[g+1]),
         .out_rem   (dv_rem[g+1]),
         .out_low   (dv_low[g+1]),
         .out_quo   (dv_quo[g+1]),
         .out_pass  (dv_pass[g+1])
      );
   end

   // sign restore
   logic      sign_valid_ff;
   vec32_type sign_unit_ff;
   vec32_type sign_unit_in;
   logic      sign_ok_ff;
   side_type  sign_side_ff;
   logic [31:0] quo32 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quo32[i]        = 32'(dv_quo[QUO_W][i]);
         sign_unit_in[i] = dv_pass[QUO_W].neg[i] ? (~quo32[i] + 32'd1) : quo32[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_valid_ff <= 1'b0;
      end else if (advance) begin
         sign_valid_ff <= dv_valid[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sign_unit_ff <= sign_unit_in;
         sign_ok_ff   <= dv_pass[QUO_W].ok;
         sign_side_ff <= dv_pass[QUO_W].side;
      end
   end

   assign out_valid = sign_valid_ff;
   assign out_unit  = sign_unit_ff;
   assign out_ok    = sign_ok_ff;
   assign out_side  = sign_side_ff;

endmodule

// File: src/gravity_aligned_rotation_top.sv
// Gravity-aligned rotation: one gravity vector (signed Q16.16) in, one 3x3
// rotation (signed Q2.30 columns x, y, z) plus a degenerate flag out.
// Input item on req_valid/req_stall/req_data, result item on
// rsp_valid/rsp_stall/rsp_data; an item moves when valid is high and
// stall is low.
// Fully pipelined: a new item may enter every cycle and one result leaves
// per cycle unless rsp_stall holds a waiting result. Each of the three
// normalising units has 74 stages (shift normalise, squares, 32-cell
// square root, 31-cell restoring divider); the axis select, cross product
// and output register follow. Divider and root chains dominate each unit.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears every stage valid, the output valid too; no item is in
// flight afterwards and req_stall drops at once.
module gravity_aligned_rotation_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gar_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gar_pkg::rsp_type rsp_data
);
   import gar_pkg::*;

   logic      advance;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // z = unit(g)
   vec64_type grav_comp;
   side_type  u1_side;
   logic      u1_valid;
   vec32_type u1_unit;
   logic      u1_ok;
   side_type  u1_side_out;

   assign grav_comp[0] = 64'(req_data.grav_x);
   assign grav_comp[1] = 64'(req_data.grav_y);
   assign grav_comp[2] = 64'(req_data.grav_z);

   always_comb begin
      u1_side    = '0;
      u1_side.ok = 1'b1;
   end

   gar_unit u_unit_z (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_comp   (grav_comp),
      .in_side   (u1_side),
      .out_valid (u1_valid),
      .out_unit  (u1_unit),
      .out_ok    (u1_ok),
      .out_side  (u1_side_out)
   );

   // helper axis choice and z cross helper
   logic        sel_valid_ff;
   vec64_type   sel_comp_ff;
   vec64_type   sel_comp_in;
   side_type    sel_side_ff;
   side_type    sel_side_in;
   logic [31:0] abs_z0;
   logic [31:0] abs_z1;
   logic [63:0] zw [3];

   always_comb begin
      abs_z0 = u1_unit[0][31] ? (~u1_unit[0] + 32'd1) : u1_unit[0];
      abs_z1 = u1_unit[1][31] ? (~u1_unit[1] + 32'd1) : u1_unit[1];
      for (int i = 0; i < 3; i++) begin
         zw[i] = 64'($signed(u1_unit[i]));
      end
      if (abs_z0 < abs_z1) begin
         sel_comp_in[0] = '0;
         sel_comp_in[1] = zw[2];
         sel_comp_in[2] = ~zw[1] + 64'd1;
      end else begin
         sel_comp_in[0] = ~zw[2] + 64'd1;
         sel_comp_in[1] = '0;
         sel_comp_in[2] = zw[0];
      end
      sel_side_in    = '0;
      sel_side_in.ok = u1_ok & u1_side_out.ok;
      sel_side_in.z  = u1_unit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (advance) begin
         sel_valid_ff <= u1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sel_comp_ff <= sel_comp_in;
         sel_side_ff <= sel_side_in;
      end
   end

   // x = unit(z cross helper)
   logic      u2_valid;
   vec32_type u2_unit;
   logic      u2_ok;
   side_type  u2_side_out;

   gar_unit u_unit_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sel_valid_ff),
      .in_comp   (sel_comp_ff),
      .in_side   (sel_side_ff),
      .out_valid (u2_valid),
      .out_unit  (u2_unit),
      .out_ok    (u2_ok),
      .out_side  (u2_side_out)
   );

   // z cross x: products, then differences
   logic               prod_valid_ff;
   logic signed [63:0] prod_ff [6];
   logic signed [63:0] prod_in [6];
   side_type           prod_side_ff;
   side_type           prod_side_in;

   always_comb begin
      prod_in[0] = $signed(u2_side_out.z[1]) * $signed(u2_unit[2]);
      prod_in[1] = $signed(u2_side_out.z[2]) * $signed(u2_unit[1]);
      prod_in[2] = $signed(u2_side_out.z[2]) * $signed(u2_unit[0]);
      prod_in[3] = $signed(u2_side_out.z[0]) * $signed(u2_unit[2]);
      prod_in[4] = $signed(u2_side_out.z[0]) * $signed(u2_unit[1]);
      prod_in[5] = $signed(u2_side_out.z[1]) * $signed(u2_unit[0]);
      prod_side_in    = u2_side_out;
      prod_side_in.ok = u2_ok & u2_side_out.ok;
      prod_side_in.x  = u2_unit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= u2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff      <= prod_in;
         prod_side_ff <= prod_side_in;
      end
   end

   logic      diff_valid_ff;
   vec64_type diff_ff;
   side_type  diff_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
      end else if (advance) begin
         diff_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff[0]   <= prod_ff[0] - prod_ff[1];
         diff_ff[1]   <= prod_ff[2] - prod_ff[3];
         diff_ff[2]   <= prod_ff[4] - prod_ff[5];
         diff_side_ff <= prod_side_ff;
      end
   end

   // y = unit(z cross x)
   logic      u3_valid;
   vec32_type u3_unit;
   logic      u3_ok;
   side_type  u3_side_out;
   logic      all_ok;

   gar_unit u_unit_y (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (diff_valid_ff),
      .in_comp   (diff_ff),
      .in_side   (diff_side_ff),
      .out_valid (u3_valid),
      .out_unit  (u3_unit),
      .out_ok    (u3_ok),
      .out_side  (u3_side_out)
   );

   always_comb begin
      all_ok = u3_ok & u3_side_out.ok;
      rsp_data_in            = '0;
      rsp_data_in.degenerate = !all_ok;
      if (all_ok) begin
         rsp_data_in.col0_row0 = u3_side_out.x[0];
         rsp_data_in.col0_row1 = u3_side_out.x[1];
         rsp_data_in.col0_row2 = u3_side_out.x[2];
         rsp_data_in.col1_row0 = u3_unit[0];
         rsp_data_in.col1_row1 = u3_unit[1];
         rsp_data_in.col1_row2 = u3_unit[2];
         rsp_data_in.col2_row0 = u3_side_out.z[0];
         rsp_data_in.col2_row1 = u3_side_out.z[1];
         rsp_data_in.col2_row2 = u3_side_out.z[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= u3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: bench/gravity_aligned_rotation_top_tb.sv
`timescale 1ns / 100ps

module gravity_aligned_rotation_top_tb;
   import gar_pkg::*;

   typedef longint trip_type[3];

   typedef struct {
      req_type grav;
      bit      typed;
      rsp_type rot;
   } stim_row_type;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   rsp_type rot_expected[$];
   int      err_count = 0;
   bit      hold_long = 0;

   gravity_aligned_rotation_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   initial begin
      #2ms;
      $display("gravity_aligned_rotation_top_tb: errors");
      $finish;
   end

   function automatic longint unsigned root64(input longint unsigned s);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // scale to unit length at Q(OUT_FRAC_BITS), rounding half away from zero
   function automatic bit to_unit(input trip_type c, output trip_type u);
      longint unsigned m[3];
      bit neg[3];
      longint unsigned mx, s, n, q;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = c[i] < 0;
         m[i] = neg[i] ? -c[i] : c[i];
         if (m[i] > mx) mx = m[i];
         u[i] = 0;
      end
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         mx = mx >> 1;
      end
      while (mx < (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         mx = mx << 1;
      end
      for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
      n = root64(s);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << (OUT_FRAC_BITS + 1)) + n) / (2 * n);
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function automatic longint mag(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic rsp_type predict_rotation(input req_type g);
      trip_type gv, z, c, x, y;
      bit ok;
      rsp_type r;
      gv[0] = longint'(g.grav_x);
      gv[1] = longint'(g.grav_y);
      gv[2] = longint'(g.grav_z);
      ok = to_unit(gv, z);
      if (ok) begin
         // helper axis: (1,0,0) when z leans towards y, else (0,1,0)
         if (mag(z[0]) < mag(z[1])) begin
            c[0] = 0; c[1] = z[2]; c[2] = -z[1];
         end else begin
            c[0] = -z[2]; c[1] = 0; c[2] = z[0];
         end
         ok = to_unit(c, x);
      end
      if (ok) begin
         c[0] = z[1] * x[2] - z[2] * x[1];
         c[1] = z[2] * x[0] - z[0] * x[2];
         c[2] = z[0] * x[1] - z[1] * x[0];
         ok = to_unit(c, y);
      end
      r = '0;
      if (ok) begin
         r.col0_row0 = 32'(x[0]); r.col0_row1 = 32'(x[1]); r.col0_row2 = 32'(x[2]);
         r.col1_row0 = 32'(y[0]); r.col1_row1 = 32'(y[1]); r.col1_row2 = 32'(y[2]);
         r.col2_row0 = 32'(z[0]); r.col2_row1 = 32'(z[1]); r.col2_row2 = 32'(z[2]);
      end
      r.degenerate = !ok;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name,
                  $signed(want), $signed(got));
         err_count++;
      end
   endfunction

   function automatic void check_rotation(input rsp_type want, input rsp_type got);
      check_field("col0_row0", want.col0_row0, got.col0_row0);
      check_field("col0_row1", want.col0_row1, got.col0_row1);
      check_field("col0_row2", want.col0_row2, got.col0_row2);
      check_field("col1_row0", want.col1_row0, got.col1_row0);
      check_field("col1_row1", want.col1_row1, got.col1_row1);
      check_field("col1_row2", want.col1_row2, got.col1_row2);
      check_field("col2_row0", want.col2_row0, got.col2_row0);
      check_field("col2_row1", want.col2_row1, got.col2_row1);
      check_field("col2_row2", want.col2_row2, got.col2_row2);
      check_field("degenerate", 32'(want.degenerate), 32'(got.degenerate));
   endfunction

   // offer one item after a random gap; returns once it is taken
   task automatic send_item(input req_type g, input bit typed, input rsp_type rot);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= g;
      do @(posedge clock); while (req_stall);
      rot_expected.push_back(typed ? rot : predict_rotation(g));
   endtask

   function automatic logic [31:0] rand_comp(input int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 255) - 128;
         2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         3: return 0;
         default: return $signed($urandom_range(0, 2 * 65536)) - 65536;
      endcase
   endfunction

   // result side
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = hold_long ? 300 : $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0 && !hold_long) n = 0;
         if (hold_long) hold_long = 0;
         if (n != 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!rsp_valid);
         if (rot_expected.size() == 0) begin
            $display("%0t: result with none expected, got %p", $time, rsp_data);
            err_count++;
         end else begin
            check_rotation(rot_expected[0], rsp_data);
            rot_expected.delete(0);
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      req_type g;
      int kind;

      // zero input: flagged, all zero
      row.grav = '0; row.typed = 1; row.rot = '0; row.rot.degenerate = 1;
      rows.push_back(row);
      // gravity along +z, helper (0,1,0)
      row.grav = '{0, 0, 32'sd65536}; row.rot = '0;
      row.rot.col0_row0 = -32'sd1073741824;
      row.rot.col1_row1 = -32'sd1073741824;
      row.rot.col2_row2 = 32'sd1073741824;
      rows.push_back(row);
      row.typed = 0;
      row.grav = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}; rows.push_back(row);
      row.grav = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}; rows.push_back(row);
      row.grav = '{32'sh8000_0000, 0, 0}; rows.push_back(row);
      row.grav = '{0, 32'sh8000_0000, 0}; rows.push_back(row);
      row.grav = '{0, 0, 32'sh8000_0000}; rows.push_back(row);
      row.grav = '{32'sh7fff_ffff, 0, 0}; rows.push_back(row);
      row.grav = '{0, 32'sh7fff_ffff, 0}; rows.push_back(row);
      row.grav = '{1, 0, 0}; rows.push_back(row);
      row.grav = '{0, 1, 0}; rows.push_back(row);
      row.grav = '{0, 0, -1}; rows.push_back(row);
      row.grav = '{-1, -1, -1}; rows.push_back(row);
      // equal |x| and |y|: tie goes to the (0,1,0) helper
      row.grav = '{1000, 1000, 5}; rows.push_back(row);
      row.grav = '{-1000, 1000, -5}; rows.push_back(row);
      row.grav = '{999, 1000, 0}; rows.push_back(row);
      row.grav = '{32'sh8000_0000, 32'sh7fff_ffff, 1}; rows.push_back(row);
      row.grav = '{32'sh7fff_ffff, 32'sh8000_0000, -1}; rows.push_back(row);
      row.grav = '{3, -4, 12}; rows.push_back(row);

      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) send_item(rows[i].grav, rows[i].typed, rows[i].rot);

      for (int i = 0; i < 500; i++) begin
         if (i == 150) hold_long = 1;
         if (i == 300) begin
            req_valid <= 0;
            wait (rot_expected.size() == 0);
            @(posedge clock);
         end
         kind = $urandom_range(0, 5);
         g.grav_x = rand_comp(kind == 5 ? $urandom_range(0, 4) : kind);
         g.grav_y = rand_comp(kind == 5 ? $urandom_range(0, 4) : kind);
         g.grav_z = rand_comp(kind == 5 ? $urandom_range(0, 4) : kind);
         if ($urandom_range(0, 15) == 0) g.grav_y = $urandom_range(0, 1) ?
            g.grav_x : -g.grav_x;
         send_item(g, 0, '0);
      end
      req_valid <= 0;

      wait (rot_expected.size() == 0);
      repeat (300) @(posedge clock);
      if (err_count == 0 && rot_expected.size() == 0) begin
         $display("gravity_aligned_rotation_top_tb: clean");
      end else begin
         $display("gravity_aligned_rotation_top_tb: errors");
      end
      $finish;
   end

endmodule
